/* hw/rtl/sau_pkg.sv */
`timescale 1ns / 1ps

package sau_pkg;

  localparam int unsigned SizeW  = 48;
  localparam int unsigned UpperW = 16;
  localparam int unsigned LowerW = 32;
  localparam int unsigned AluW   = SizeW + 1;
  localparam int unsigned CntW   = $clog2(SizeW);

  localparam logic [UpperW-1:0] HalfTurn = 16'h8000;

  typedef enum logic [2:0] {
    ActAdd = 3'd0,
    ActSub = 3'd1,
    ActMul = 3'd2,
    ActDiv = 3'd3,
    ActLt  = 3'd4,
    ActGt  = 3'd5
  } action_e;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic [AluW-1:0] x;
    logic [AluW-1:0] y;
    logic            sub;
  } alu_req_t;

endpackage

/* hw/rtl/size_arithmetic_unit_48bit.sv */
`timescale 1ns / 1ps
// Add, subtract, compare and the divide special cases are resolved in the execute state;
// multiply runs a shift-add loop over operand_b until its remaining bits are zero, and a
// full divide runs a restoring loop over every quotient bit and then a rounding step, both
// on one shared 49-bit adder. A result waits in the done state while the output is stalled.
// Throughput: one transaction at a time; the next is taken once the result enters the
// output register. Reset (rst_ni low, asynchronous) returns to idle with no output valid.
module size_arithmetic_unit_48bit import sau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // operand_a[47:0], operand_b[95:48]
  input  logic [2:0]  s_axis_tuser_i,  // action[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o   // result_value[47:0], compare_true[48], zero pad
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFix  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]       state_q, state_d;
  action_e          act_q, act_d;
  logic [SizeW-1:0] a_q, a_d;
  logic [SizeW-1:0] b_q, b_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SizeW-1:0] res_q, res_d;
  logic             flag_q, flag_d;
  logic             m_valid_q, m_valid_d;
  logic [SizeW-1:0] m_res_q, m_res_d;
  logic             m_flag_q, m_flag_d;

  alu_req_t         alu_req;
  logic [AluW-1:0]  alu_sum;
  logic             alu_carry;
  logic [SizeW-1:0] cmp_x, cmp_y;
  logic             cmp_before;
  logic [AluW-1:0]  div_shift;
  logic             accept;
  logic             out_free;

  sau_alu u_alu (
    .req_i   (alu_req),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  sau_cmp u_cmp (
    .x_i      (cmp_x),
    .y_i      (cmp_y),
    .before_o (cmp_before)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, m_flag_q, m_res_q};

  assign cmp_x     = (act_q == ActGt) ? b_q : a_q;
  assign cmp_y     = (act_q == ActGt) ? a_q : b_q;
  assign div_shift = {rem_q, a_q[SizeW-1]};

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    a_d       = a_q;
    b_d       = b_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    flag_d    = flag_q;
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    m_flag_d  = m_flag_q;
    alu_req   = '{x: {1'b0, a_q}, y: {1'b0, b_q}, sub: 1'b0};

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          act_d   = action_e'(s_axis_tuser_i);
          a_d     = s_axis_tdata_i[SizeW-1:0];
          b_d     = s_axis_tdata_i[2*SizeW-1:SizeW];
          state_d = StExec;
        end
      end
      StExec: begin
        res_d   = '0;
        flag_d  = 1'b0;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = StDone;
        case (act_q)
          ActAdd: begin
            res_d = alu_sum[SizeW-1:0];
          end
          ActSub: begin
            alu_req.sub = 1'b1;
            res_d       = alu_sum[SizeW-1:0];
          end
          ActMul: begin
            state_d = StMul;
          end
          ActDiv: begin
            // Trial b - a: carry set means the divisor is not below the dividend.
            alu_req = '{x: {1'b0, b_q}, y: {1'b0, a_q}, sub: 1'b1};
            if (a_q == '0) begin
              res_d = '0;
            end else if (b_q == '0) begin
              res_d = '1;
            end else if (alu_carry) begin
              res_d = {{(SizeW-1){1'b0}}, 1'b1};
            end else begin
              state_d = StDiv;
            end
          end
          ActLt, ActGt: begin
            flag_d = cmp_before;
          end
          default: begin
          end
        endcase
      end
      StMul: begin
        // Shift-add: rem holds the running product, a the shifted multiplicand.
        alu_req = '{x: {1'b0, rem_q}, y: {1'b0, (b_q[0] ? a_q : {SizeW{1'b0}})}, sub: 1'b0};
        rem_d   = alu_sum[SizeW-1:0];
        a_d     = {a_q[SizeW-2:0], 1'b0};
        b_d     = {1'b0, b_q[SizeW-1:1]};
        if (b_q[SizeW-1:1] == '0) begin
          res_d   = alu_sum[SizeW-1:0];
          state_d = StDone;
        end
      end
      StDiv: begin
        // Restoring division; quotient bits shift into a from the bottom.
        alu_req = '{x: div_shift, y: {1'b0, b_q}, sub: 1'b1};
        rem_d   = alu_carry ? alu_sum[SizeW-1:0] : div_shift[SizeW-1:0];
        a_d     = {a_q[SizeW-2:0], alu_carry};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(SizeW - 1)) begin
          state_d = StFix;
        end
      end
      StFix: begin
        // Round the quotient up when a remainder is left.
        alu_req = '{x: {1'b0, a_q}, y: {{(AluW-1){1'b0}}, (rem_q != '0)}, sub: 1'b0};
        res_d   = alu_sum[SizeW-1:0];
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_res_d   = res_q;
          m_flag_d  = flag_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    a_q      <= a_d;
    b_q      <= b_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    flag_q   <= flag_d;
    m_res_q  <= m_res_d;
    m_flag_q <= m_flag_d;
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StExec)
    else $error("accepted transaction did not enter execution");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> b_q != '0)
    else $error("division running with a zero divisor");

  a_flag_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && flag_q) |-> res_q == '0)
    else $error("compare result carries a nonzero value");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_free) |=> m_valid_q && s_axis_tready_o)
    else $error("finished result was not loaded into the output register");

endmodule

/* hw/rtl/sau_alu.sv */
`timescale 1ns / 1ps

module sau_alu import sau_pkg::*; (
  input  alu_req_t        req_i,
  output logic [AluW-1:0] sum_o,
  output logic            carry_o
);

  logic [AluW:0] full;

  // With sub set, carry out is high exactly when x >= y.
  always_comb begin
    full = {1'b0, req_i.x} + {1'b0, req_i.y ^ {AluW{req_i.sub}}} + {{AluW{1'b0}}, req_i.sub};
    sum_o   = full[AluW-1:0];
    carry_o = full[AluW];
  end

endmodule

/* hw/rtl/sau_cmp.sv */
`timescale 1ns / 1ps

module sau_cmp import sau_pkg::*; (
  input  logic [SizeW-1:0] x_i,
  input  logic [SizeW-1:0] y_i,
  output logic             before_o
);

  logic [UpperW-1:0] xu;
  logic [UpperW-1:0] yu;
  logic [UpperW-1:0] diff;

  // Upper parts are ordered as serial numbers; lower parts only break ties.
  always_comb begin
    xu   = x_i[SizeW-1:LowerW];
    yu   = y_i[SizeW-1:LowerW];
    diff = xu - yu;
    if (diff == '0) begin
      before_o = x_i[LowerW-1:0] < y_i[LowerW-1:0];
    end else begin
      before_o = (diff > HalfTurn) || ((diff == HalfTurn) && (xu > yu));
    end
  end

endmodule

/* tb/size_arithmetic_unit_48bit_tb.sv */
`timescale 1ns / 1ps

module size_arithmetic_unit_48bit_tb;
  import sau_pkg::*;

  localparam logic [2:0]        ActSpare6   = 3'd6;
  localparam logic [2:0]        ActSpare7   = 3'd7;
  localparam logic [SizeW-1:0]  MaxSize     = {SizeW{1'b1}};
  localparam int unsigned       RandomItems = 1900;
  localparam int unsigned       DrainEvery  = 400;

  typedef struct {
    logic [2:0]       action;
    logic [SizeW-1:0] a;
    logic [SizeW-1:0] b;
    bit               drain;  // hold this transaction until every result is back
  } size_req_t;

  typedef struct {
    logic [SizeW-1:0] value;
    logic             flag;
  } size_res_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i  = '0;  // operand_a[47:0], operand_b[95:48]
  logic [2:0]  s_axis_tuser_i  = '0;  // action[2:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;        // result_value[47:0], compare_true[48], zero pad

  size_req_t   request_q[$];
  size_res_t   predicted_q[$];
  size_req_t   on_bus;
  int unsigned error_cnt    = 0;
  int unsigned checked_cnt  = 0;
  int unsigned drain_cnt    = 0;
  int unsigned action_cnt[8];

  size_arithmetic_unit_48bit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Serial order on the upper parts, plain order on the lower parts.
  function automatic bit size_precedes(logic [SizeW-1:0] x, logic [SizeW-1:0] y);
    logic [UpperW-1:0] xu;
    logic [UpperW-1:0] yu;
    logic [UpperW-1:0] diff;
    xu   = x[SizeW-1:LowerW];
    yu   = y[SizeW-1:LowerW];
    diff = xu - yu;
    if (diff == '0) return x[LowerW-1:0] < y[LowerW-1:0];
    if (diff > HalfTurn) return 1'b1;
    return (diff == HalfTurn) && (xu > yu);
  endfunction

  function automatic size_res_t predict_size_result(size_req_t req);
    size_res_t res;
    res.value = '0;
    res.flag  = 1'b0;
    case (req.action)
      ActAdd: res.value = req.a + req.b;
      ActSub: res.value = req.a - req.b;
      ActMul: res.value = req.a * req.b;
      ActDiv: begin
        if (req.a == '0) res.value = '0;
        else if (req.b == '0) res.value = MaxSize;
        else if (req.b >= req.a) res.value = 48'd1;
        else res.value = req.a / req.b + SizeW'((req.a % req.b) != '0);
      end
      ActLt: res.flag = size_precedes(req.a, req.b);
      ActGt: res.flag = size_precedes(req.b, req.a);
      default: ;
    endcase
    return res;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    logic [SizeW-1:0] v;
    v = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = MaxSize;
      2: v = SizeW'($urandom_range(0, 255));
      3: v = 48'd1 << $urandom_range(0, SizeW - 1);
      4: v = MaxSize - SizeW'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [SizeW-1:0] got,
                                 input logic [SizeW-1:0] want);
    error_cnt++;
    $display("%0t: result %0d: %s: got %h, expected %h", $time, checked_cnt, what, got, want);
  endtask

  task automatic add_item(input logic [2:0] action, input logic [SizeW-1:0] a,
                          input logic [SizeW-1:0] b, input bit drain);
    size_req_t req;
    req.action = action;
    req.a      = a;
    req.b      = b;
    req.drain  = drain;
    request_q.push_back(req);
  endtask

  // Driver: presents one request at a time, with random gaps between transactions.
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i) begin
    logic next_valid;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted_q.push_back(predict_size_result(on_bus));
        action_cnt[on_bus.action]++;
        next_valid = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
        end
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && predicted_q.size() > 0)) begin
          on_bus = request_q.pop_front();
          if (on_bus.drain) drain_cnt++;
          next_valid = 1'b1;
          s_axis_tdata_i <= {on_bus.b, on_bus.a};
          s_axis_tuser_i <= on_bus.action;
        end
      end
      s_axis_tvalid_i <= next_valid;
    end
  end

  // Monitor: random back-pressure, and every result checked against the oldest prediction.
  int unsigned recv_stall = 0;
  int unsigned recv_calm  = 0;

  always @(posedge clk_i) begin
    size_res_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        checked_cnt++;
        if (predicted_q.size() == 0) begin
          report_mismatch("result with no request outstanding", m_axis_tdata_o[SizeW-1:0], '0);
        end else begin
          want = predicted_q.pop_front();
          if (m_axis_tdata_o[SizeW-1:0] !== want.value)
            report_mismatch("result_value", m_axis_tdata_o[SizeW-1:0], want.value);
          if (m_axis_tdata_o[SizeW] !== want.flag)
            report_mismatch("compare_true", SizeW'(m_axis_tdata_o[SizeW]), SizeW'(want.flag));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
          if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 100);
        end
      end
    end
  end

  initial begin
    logic [2:0]       act;
    logic [SizeW-1:0] a;
    logic [SizeW-1:0] b;
    int unsigned      r;

    // Wrapping arithmetic at the extremes.
    add_item(ActAdd, MaxSize, MaxSize, 1'b0);
    add_item(ActAdd, '0, '0, 1'b0);
    add_item(ActAdd, MaxSize, 48'd1, 1'b0);
    add_item(ActSub, '0, 48'd1, 1'b0);
    add_item(ActSub, MaxSize, '0, 1'b0);
    add_item(ActMul, MaxSize, MaxSize, 1'b0);
    add_item(ActMul, 48'h0001_0000_0000, 48'h0000_0001_0000, 1'b0);
    add_item(ActMul, 48'd3, MaxSize, 1'b0);
    // Divide: zero dividend, zero divisor, divisor not smaller, exact quotients, rounding up.
    add_item(ActDiv, '0, 48'd5, 1'b0);
    add_item(ActDiv, '0, '0, 1'b0);
    add_item(ActDiv, 48'd7, '0, 1'b0);
    add_item(ActDiv, 48'd5, 48'd9, 1'b0);
    add_item(ActDiv, 48'd5, 48'd5, 1'b0);
    add_item(ActDiv, MaxSize, 48'd1, 1'b0);
    add_item(ActDiv, 48'd10, 48'd3, 1'b0);
    add_item(ActDiv, 48'd9, 48'd3, 1'b0);
    add_item(ActDiv, MaxSize, MaxSize - 48'd1, 1'b0);
    // Compares: equal uppers, wrap-around uppers, uppers exactly half a turn apart.
    add_item(ActLt, 48'h1234_0000_0001, 48'h1234_0000_0002, 1'b0);
    add_item(ActGt, 48'h1234_FFFF_FFFF, 48'h1234_0000_0000, 1'b0);
    add_item(ActLt, 48'hFFFF_0000_0000, 48'h0001_0000_0000, 1'b0);
    add_item(ActLt, 48'h8000_0000_0000, 48'h0000_0000_0000, 1'b0);
    add_item(ActGt, 48'h8000_0000_0000, 48'h0000_0000_0000, 1'b0);
    add_item(ActGt, 48'h0000_0000_0000, 48'h8000_0000_0000, 1'b0);
    add_item(ActLt, MaxSize, MaxSize, 1'b0);
    // Codes with no operation behind them.
    add_item(ActSpare6, MaxSize, 48'd1, 1'b0);
    add_item(ActSpare7, 48'd1, MaxSize, 1'b0);

    for (int i = 0; i < RandomItems; i++) begin
      r   = $urandom_range(0, 99);
      act = (r < 1) ? ActSpare6 : (r < 2) ? ActSpare7 : 3'($urandom_range(ActAdd, ActGt));
      a   = rand_size();
      b   = rand_size();
      if (act == ActLt || act == ActGt) begin
        case ($urandom_range(0, 5))
          0, 1: b[SizeW-1:LowerW] = a[SizeW-1:LowerW];
          2: b[SizeW-1:LowerW] = a[SizeW-1:LowerW] ^ HalfTurn;
          3: b[SizeW-1:LowerW] = a[SizeW-1:LowerW] + 16'($urandom_range(0, 4)) - 16'd2;
          4: b = a;
          default: ;
        endcase
      end else if (act == ActDiv) begin
        case ($urandom_range(0, 5))
          0: b = SizeW'($urandom_range(1, 1000));
          1: b = a;
          2: b = a + 48'd1;
          3: b = a >> $urandom_range(1, SizeW - 1);
          default: ;
        endcase
      end
      // The first random transaction and every so often another wait for a drained pipe.
      add_item(act, a, b, (i % DrainEvery) == 0);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Sample the queues between edges so that the driver and monitor have settled.
    while (request_q.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (predicted_q.size() != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d, lt %0d, gt %0d,",
             checked_cnt, action_cnt[ActAdd], action_cnt[ActSub], action_cnt[ActMul],
             action_cnt[ActDiv], action_cnt[ActLt], action_cnt[ActGt]);
    $display("unused codes %0d, full drains %0d, mismatches %0d.",
             action_cnt[ActSpare6] + action_cnt[ActSpare7], drain_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("size_arithmetic_unit_48bit_tb OK");
    end else begin
      $display("size_arithmetic_unit_48bit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d requests queued and %0d results outstanding.",
             request_q.size(), predicted_q.size());
    $display("size_arithmetic_unit_48bit_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/sau_pkg.sv
hw/rtl/sau_alu.sv
hw/rtl/sau_cmp.sv
hw/rtl/size_arithmetic_unit_48bit.sv
tb/size_arithmetic_unit_48bit_tb.sv
